// File: rtl/mesisb_pkg.sv
// ----------------------------------------------------------------------------
// mesisb_pkg
// Shared widths, codes and types of the MESI snooping bus controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mesisb_pkg;

   localparam int CORES       = 4;
   localparam int CORE_W      = 2;
   localparam int BLOCK_WORDS = 8;
   localparam int WORD_W      = 3;
   localparam int LINES       = 64;
   localparam int LINE_W      = 6;
   localparam int TAG_W       = 12;
   localparam int ADDR_W      = 21;
   localparam int MEM_AW      = 21;
   localparam int MEM_WORDS   = 2 ** MEM_AW;
   localparam int DATA_AW     = CORE_W + LINE_W + WORD_W;
   localparam int DATA_WORDS  = 2 ** DATA_AW;
   localparam int DELAY_W     = 8;
   localparam int CSR_AW      = 3;

   localparam logic [DELAY_W-1:0] BUS_DELAY_RESET = 8'd16;

   // request commands
   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_REQUEST = 3'd1;
   localparam logic [2:0] CMD_CWRITE  = 3'd2;
   localparam logic [2:0] CMD_LWRITE  = 3'd3;
   localparam logic [2:0] CMD_MWRITE  = 3'd4;
   localparam logic [2:0] CMD_INSPECT = 3'd5;

   // MESI line states
   localparam logic [1:0] MESI_I = 2'd0;
   localparam logic [1:0] MESI_S = 2'd1;
   localparam logic [1:0] MESI_E = 2'd2;
   localparam logic [1:0] MESI_M = 2'd3;

   // bus wire commands
   localparam logic [1:0] BC_NONE  = 2'd0;
   localparam logic [1:0] BC_RD    = 2'd1;
   localparam logic [1:0] BC_RDX   = 2'd2;
   localparam logic [1:0] BC_FLUSH = 2'd3;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [1:0]       state;
   } entry_type;

   localparam int ENTRY_W = TAG_W + 2;

   typedef struct packed {
      logic [1:0]        bus_cmd;
      logic [CORE_W-1:0] origin;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       data;
      logic              shared;
      logic [CORES-1:0]  done;
      logic [CORES-1:0]  pending;
      logic [31:0]       read_word;
      logic [31:0]       cache_word;
      logic [TAG_W-1:0]  line_tag;
      logic [1:0]        line_state;
      logic [ADDR_W-1:0] max_addr;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/mesi_snoop_bus_controller_core.sv
// Steps: after acceptance a request passes FS_READ (read the stores), FS_EXEC
//   (modify and write back) and FS_DONE (load the response register, held off while a stalled response waits).
// Requests: a new request is taken only once the last one is back in idle; the
//   tag/state, data and main memories are read through a register before the write back.
// Reset: control clears at once; then a clearing pass over all 2097152 words zeroes
//   main memory (and the cache data store) before the first request is taken.
// ----------------------------------------------------------------------------
// mesi_snoop_bus_controller_core
// Snooping bus with round-robin grant, MESI state per cache line, backed by
// main memory; backdoor writes and inspection of every store.
// ----------------------------------------------------------------------------
`default_nettype none

module mesi_snoop_bus_controller_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [2:0]                       req_cmd,
   input  wire logic [1:0]                       req_core,
   input  wire logic [mesisb_pkg::ADDR_W-1:0]    req_address,
   input  wire logic                             req_exclusive,
   input  wire logic [31:0]                      req_data_in,
   input  wire logic [mesisb_pkg::TAG_W-1:0]     req_tag_in,
   input  wire logic [1:0]                       req_state_in,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [1:0]                            rsp_bus_cmd_out,
   output logic [1:0]                            rsp_bus_origin,
   output logic [mesisb_pkg::ADDR_W-1:0]         rsp_bus_addr_out,
   output logic [31:0]                           rsp_bus_data_out,
   output logic                                  rsp_bus_shared_out,
   output logic [3:0]                            rsp_done_mask,
   output logic [3:0]                            rsp_pending_mask,
   output logic [31:0]                           rsp_read_word,
   output logic [31:0]                           rsp_cache_word,
   output logic [mesisb_pkg::TAG_W-1:0]          rsp_line_tag,
   output logic [1:0]                            rsp_line_state,
   output logic [mesisb_pkg::ADDR_W-1:0]         rsp_max_addr,
   // configuration
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mesisb_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   import mesisb_pkg::*;

   typedef enum logic [4:0] {
      FS_CLEAR = 5'b00001,
      FS_IDLE  = 5'b00010,
      FS_READ  = 5'b00100,
      FS_EXEC  = 5'b01000,
      FS_DONE  = 5'b10000
   } fsm_type;

   fsm_type state_ff, state_in;

   // request held while it is worked on
   logic [2:0]        cmd_ff;
   logic [CORE_W-1:0] core_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              excl_ff;
   logic [31:0]       din_ff;
   logic [TAG_W-1:0]  tin_ff;
   logic [1:0]        sin_ff;

   logic [CORES-1:0]  pend_ff, pend_in, done_ff, done_in, rexcl_ff, rexcl_in;
   logic [ADDR_W-1:0] raddr_ff [CORES];
   logic [ADDR_W-1:0] raddr_in [CORES];

   logic              busy_ff, busy_in;
   logic [DELAY_W-1:0] cool_ff, cool_in, delay_ff, delay_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [1:0]        cur_cmd_ff, cur_cmd_in;
   logic [CORE_W-1:0] cur_org_ff, cur_org_in;
   logic [ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic [31:0]       cur_data_ff, cur_data_in;
   logic              shared_ff, shared_in;
   logic [1:0]        pfs_ff, pfs_in;
   logic              pfv_ff, pfv_in;
   logic [CORE_W-1:0] last_ff, last_in;
   logic [ADDR_W-1:0] high_ff, high_in;

   logic              gfound_ff, gfound_in;
   logic [CORE_W-1:0] gid_ff, gid_in;
   logic [LINE_W-1:0] ridx_ff, ridx_in;
   logic [MEM_AW-1:0] clr_ff, clr_in;

   logic [31:0]       irw_ff, irw_in, icw_ff, icw_in;
   logic [TAG_W-1:0]  ilt_ff, ilt_in;
   logic [1:0]        ils_ff, ils_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [LINES-1:0]  lvalid_ff [CORES];

   // memory ports
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr, mem_raddr;
   logic [31:0]       mem_wdata, mem_rdata;
   logic              dat_we;
   logic [DATA_AW-1:0] dat_waddr, dat_raddr;
   logic [31:0]       dat_wdata, dat_rdata;
   logic [CORES-1:0]  ent_we;
   logic [LINE_W-1:0] ent_waddr, ent_raddr;
   entry_type         ent_wdata [CORES];
   entry_type         ent_rdata [CORES];
   entry_type         ent [CORES];

   logic              pick_found;
   logic [CORE_W-1:0] pick_id;
   logic              accept, rsp_free, ok, csr_wr;

   assign accept    = req_valid && (state_ff == FS_IDLE);
   assign req_stall = (state_ff != FS_IDLE);
   assign rsp_free  = !(rsp_valid_ff && rsp_stall);
   assign ok        = (int'(core_ff) < CORES);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];

   // ---- memories ----
   mesisb_ram #(.DEPTH(MEM_WORDS), .WIDTH(32)) u_main (
      .clock, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(mem_rdata)
   );

   mesisb_ram #(.DEPTH(DATA_WORDS), .WIDTH(32)) u_data (
      .clock, .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
      .raddr(dat_raddr), .rdata(dat_rdata)
   );

   for (genvar g = 0; g < CORES; g++) begin : g_tag
      logic [ENTRY_W-1:0] rd_w;
      mesisb_ram #(.DEPTH(LINES), .WIDTH(ENTRY_W)) u_tag (
         .clock, .we(ent_we[g]), .waddr(ent_waddr), .wdata(ent_wdata[g]),
         .raddr(ent_raddr), .rdata(rd_w)
      );
      assign ent_rdata[g] = entry_type'(rd_w);
      // a never-written line reads as invalid with tag zero
      assign ent[g] = lvalid_ff[g][ridx_ff] ? ent_rdata[g] : '0;
   end

   // ---- round-robin pick, starting after the origin of the last bus transfer ----
   always_comb begin
      logic [CORE_W-1:0] cand;
      pick_found = 1'b0;
      pick_id    = '0;
      for (int i = CORES - 1; i >= 0; i--) begin
         cand = last_ff + CORE_W'(i + 1);
         if (pend_ff[cand] && !done_ff[cand]) begin
            pick_found = 1'b1;
            pick_id    = cand;
         end
      end
   end

   // read addresses, valid in FS_READ
   always_comb begin
      if (cmd_ff == CMD_TICK) begin
         ent_raddr = busy_ff ? cur_addr_ff[WORD_W +: LINE_W]
                             : raddr_ff[pick_id][WORD_W +: LINE_W];
         mem_raddr = {cur_addr_ff[ADDR_W-1:WORD_W], word_ff};
         dat_raddr = {cur_org_ff, cur_addr_ff[WORD_W +: LINE_W], word_ff};
      end else begin
         ent_raddr = addr_ff[WORD_W +: LINE_W];
         mem_raddr = addr_ff;
         dat_raddr = {core_ff, addr_ff[WORD_W +: LINE_W], addr_ff[WORD_W-1:0]};
      end
   end

   // ---- sequencer ----
   always_comb begin
      logic [ADDR_W-1:0] ga, p;
      logic [TAG_W-1:0]  gtag;
      logic              rd, stop;
      logic [CORE_W-1:0] fc;
      logic [1:0]        ns;
      logic [LINE_W-1:0] cidx;

      state_in    = state_ff;
      pend_in     = pend_ff;
      done_in     = done_ff;
      rexcl_in    = rexcl_ff;
      raddr_in    = raddr_ff;
      busy_in     = busy_ff;
      cool_in     = cool_ff;
      delay_in    = csr_wr ? csr_pwdata[DELAY_W-1:0] : delay_ff;
      word_in     = word_ff;
      cur_cmd_in  = cur_cmd_ff;
      cur_org_in  = cur_org_ff;
      cur_addr_in = cur_addr_ff;
      cur_data_in = cur_data_ff;
      shared_in   = shared_ff;
      pfs_in      = pfs_ff;
      pfv_in      = pfv_ff;
      last_in     = last_ff;
      high_in     = high_ff;
      gfound_in   = gfound_ff;
      gid_in      = gid_ff;
      ridx_in     = ridx_ff;
      clr_in      = clr_ff;
      irw_in      = irw_ff;
      icw_in      = icw_ff;
      ilt_in      = ilt_ff;
      ils_in      = ils_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in      = rsp_ff;

      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = din_ff;
      dat_we    = 1'b0;
      dat_waddr = {core_ff, addr_ff[WORD_W +: LINE_W], addr_ff[WORD_W-1:0]};
      dat_wdata = din_ff;
      ent_we    = '0;
      ent_waddr = ridx_ff;
      for (int c = 0; c < CORES; c++) begin
         ent_wdata[c] = ent[c];
      end

      ga   = raddr_ff[gid_ff];
      gtag = ga[ADDR_W-1 -: TAG_W];
      rd   = !rexcl_ff[gid_ff];
      stop = 1'b0;
      fc   = '0;
      ns   = MESI_I;
      cidx = cur_addr_ff[WORD_W +: LINE_W];
      p    = {cur_addr_ff[ADDR_W-1:WORD_W], word_ff};

      case (state_ff)
         FS_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            dat_we    = (clr_ff >> DATA_AW) == '0;
            dat_waddr = clr_ff[DATA_AW-1:0];
            dat_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = FS_IDLE;
            end
         end
         FS_IDLE: begin
            if (accept) begin
               state_in = FS_READ;
            end
         end
         FS_READ: begin
            gfound_in = pick_found;
            gid_in    = pick_id;
            ridx_in   = ent_raddr;
            state_in  = FS_EXEC;
         end
         FS_EXEC: begin
            irw_in   = '0;
            icw_in   = '0;
            ilt_in   = '0;
            ils_in   = '0;
            state_in = FS_DONE;
            case (cmd_ff)
               CMD_TICK: begin
                  if (!busy_ff) begin
                     cur_cmd_in  = BC_NONE;
                     cur_org_in  = '0;
                     cur_addr_in = '0;
                     cur_data_in = '0;
                     shared_in   = 1'b0;
                     pfv_in      = 1'b0;
                     if (gfound_ff) begin
                        busy_in = 1'b1;
                        word_in = '0;
                        if (ent[gid_ff].state == MESI_M && ent[gid_ff].tag != gtag) begin
                           // evict own modified line first
                           pfs_in      = MESI_I;
                           pfv_in      = 1'b1;
                           cur_cmd_in  = BC_FLUSH;
                           cur_org_in  = gid_ff;
                           cur_addr_in = {ent[gid_ff].tag, ridx_ff, WORD_W'(0)};
                           cool_in     = '0;
                        end else begin
                           for (int c = 0; c < CORES; c++) begin
                              if (CORE_W'(c) != gid_ff && !stop
                                  && ent[c].state != MESI_I && ent[c].tag == gtag) begin
                                 shared_in = 1'b1;
                                 ns = ent[c].state;
                                 if (rd && ns == MESI_E) begin
                                    ns = MESI_S;
                                 end
                                 if (ns == MESI_M) begin
                                    stop = 1'b1;
                                    fc   = CORE_W'(c);
                                 end else if (!rd) begin
                                    ns = MESI_I;
                                 end
                                 if (ns != ent[c].state) begin
                                    ent_we[c]          = 1'b1;
                                    ent_wdata[c].state = ns;
                                 end
                              end
                           end
                           if (stop) begin
                              pfs_in      = rd ? MESI_S : MESI_I;
                              pfv_in      = 1'b1;
                              cur_cmd_in  = BC_FLUSH;
                              cur_org_in  = fc;
                              cur_addr_in = ga;
                              cool_in     = '0;
                           end else begin
                              cur_cmd_in  = rd ? BC_RD : BC_RDX;
                              cur_org_in  = gid_ff;
                              cur_addr_in = ga;
                              cool_in     = delay_ff;
                           end
                        end
                     end
                  end else if (cool_ff != '0) begin
                     cool_in = cool_ff - 1'b1;
                  end else begin
                     if (cur_cmd_ff == BC_RD || cur_cmd_ff == BC_RDX) begin
                        cur_data_in = mem_rdata;
                        dat_we      = 1'b1;
                        dat_waddr   = {cur_org_ff, cidx, word_ff};
                        dat_wdata   = mem_rdata;
                        if (p > high_ff) high_in = p;
                     end else if (cur_cmd_ff == BC_FLUSH) begin
                        cur_data_in = dat_rdata;
                        mem_we      = 1'b1;
                        mem_waddr   = p;
                        mem_wdata   = dat_rdata;
                        if (p > high_ff) high_in = p;
                     end
                     word_in = word_ff + 1'b1;
                     if (word_ff == WORD_W'(BLOCK_WORDS - 1)) begin
                        ent_we[cur_org_ff] = 1'b1;
                        case (cur_cmd_ff)
                           BC_RD: begin
                              ent_wdata[cur_org_ff] = {cur_addr_ff[ADDR_W-1 -: TAG_W],
                                                       shared_ff ? MESI_S : MESI_E};
                           end
                           BC_RDX: begin
                              ent_wdata[cur_org_ff] = {cur_addr_ff[ADDR_W-1 -: TAG_W],
                                                       MESI_M};
                           end
                           BC_FLUSH: begin
                              ent_wdata[cur_org_ff].state = pfv_ff ? pfs_ff : MESI_I;
                              pfv_in = 1'b0;
                           end
                           default: begin
                              ent_we[cur_org_ff] = 1'b0;
                           end
                        endcase
                        if (cur_cmd_ff != BC_FLUSH) begin
                           done_in[cur_org_ff] = 1'b1;
                           pend_in[cur_org_ff] = 1'b0;
                        end
                        busy_in = 1'b0;
                        last_in = cur_org_ff;
                        word_in = '0;
                     end
                  end
               end
               CMD_REQUEST: begin
                  if (ok && !pend_ff[core_ff]) begin
                     raddr_in[core_ff] = addr_ff;
                     rexcl_in[core_ff] = excl_ff;
                     pend_in[core_ff]  = 1'b1;
                     done_in[core_ff]  = 1'b0;
                  end
               end
               CMD_CWRITE: begin
                  dat_we = ok;
               end
               CMD_LWRITE: begin
                  ent_we[core_ff]    = ok;
                  ent_wdata[core_ff] = {tin_ff, sin_ff};
               end
               CMD_MWRITE: begin
                  mem_we = 1'b1;
               end
               CMD_INSPECT: begin
                  irw_in = mem_rdata;
                  if (ok) begin
                     icw_in = dat_rdata;
                     ilt_in = ent[core_ff].tag;
                     ils_in = ent[core_ff].state;
                  end
               end
               default: begin
               end
            endcase
         end
         FS_DONE: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.bus_cmd     = cur_cmd_ff;
               rsp_in.origin      = cur_org_ff;
               rsp_in.addr        = cur_addr_ff;
               rsp_in.data        = cur_data_ff;
               rsp_in.shared      = shared_ff;
               rsp_in.done        = done_ff;
               rsp_in.pending     = pend_ff;
               rsp_in.read_word   = irw_ff;
               rsp_in.cache_word  = icw_ff;
               rsp_in.line_tag    = ilt_ff;
               rsp_in.line_state  = ils_ff;
               rsp_in.max_addr    = high_ff;
               state_in           = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_CLEAR;
         pend_ff      <= '0;
         done_ff      <= '0;
         rexcl_ff     <= '0;
         busy_ff      <= 1'b0;
         cool_ff      <= '0;
         delay_ff     <= BUS_DELAY_RESET;
         word_ff      <= '0;
         cur_cmd_ff   <= BC_NONE;
         cur_org_ff   <= '0;
         cur_addr_ff  <= '0;
         cur_data_ff  <= '0;
         shared_ff    <= 1'b0;
         pfs_ff       <= MESI_I;
         pfv_ff       <= 1'b0;
         last_ff      <= '0;
         high_ff      <= '0;
         gfound_ff    <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CORES; c++) begin
            raddr_ff[c]  <= '0;
            lvalid_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         done_ff      <= done_in;
         rexcl_ff     <= rexcl_in;
         busy_ff      <= busy_in;
         cool_ff      <= cool_in;
         delay_ff     <= delay_in;
         word_ff      <= word_in;
         cur_cmd_ff   <= cur_cmd_in;
         cur_org_ff   <= cur_org_in;
         cur_addr_ff  <= cur_addr_in;
         cur_data_ff  <= cur_data_in;
         shared_ff    <= shared_in;
         pfs_ff       <= pfs_in;
         pfv_ff       <= pfv_in;
         last_ff      <= last_in;
         high_ff      <= high_in;
         gfound_ff    <= gfound_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < CORES; c++) begin
            raddr_ff[c] <= raddr_in[c];
            if (ent_we[c]) begin
               lvalid_ff[c][ent_waddr] <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         core_ff <= req_core;
         addr_ff <= req_address;
         excl_ff <= req_exclusive;
         din_ff  <= req_data_in;
         tin_ff  <= req_tag_in;
         sin_ff  <= req_state_in;
      end
      gid_ff  <= gid_in;
      ridx_ff <= ridx_in;
      irw_ff  <= irw_in;
      icw_ff  <= icw_in;
      ilt_ff  <= ilt_in;
      ils_ff  <= ils_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bus_cmd_out    = rsp_ff.bus_cmd;
   assign rsp_bus_origin     = rsp_ff.origin;
   assign rsp_bus_addr_out   = rsp_ff.addr;
   assign rsp_bus_data_out   = rsp_ff.data;
   assign rsp_bus_shared_out = rsp_ff.shared;
   assign rsp_done_mask      = rsp_ff.done;
   assign rsp_pending_mask   = rsp_ff.pending;
   assign rsp_read_word      = rsp_ff.read_word;
   assign rsp_cache_word     = rsp_ff.cache_word;
   assign rsp_line_tag       = rsp_ff.line_tag;
   assign rsp_line_state     = rsp_ff.line_state;
   assign rsp_max_addr       = rsp_ff.max_addr;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(delay_ff);

endmodule

`default_nettype wire

// File: rtl/mesisb_ram.sv
// ----------------------------------------------------------------------------
// mesisb_ram
// Single-port-write, single-port-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mesisb_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         ram_ff[waddr] <= wdata;
      end
      rdata_ff <= ram_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/mesisb_checker.sv
// ----------------------------------------------------------------------------
// mesisb_checker
// Port-level checks of the snooping bus controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mesisb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [1:0]                    rsp_bus_cmd_out,
   input wire logic [1:0]                    rsp_bus_origin,
   input wire logic [mesisb_pkg::ADDR_W-1:0] rsp_bus_addr_out,
   input wire logic [31:0]                   rsp_bus_data_out,
   input wire logic                          rsp_bus_shared_out,
   input wire logic [3:0]                    rsp_done_mask,
   input wire logic [3:0]                    rsp_pending_mask
);

   import mesisb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a core is never both pending and done
   a_masks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_done_mask & rsp_pending_mask) == 4'd0)
      else $error("core both pending and done");

   // idle bus wires are all clear
   a_idle_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_cmd_out == BC_NONE |->
         rsp_bus_origin == 2'd0 && rsp_bus_addr_out == '0
         && rsp_bus_data_out == 32'd0 && !rsp_bus_shared_out)
      else $error("bus wires not clear while idle");

endmodule

bind mesi_snoop_bus_controller_core mesisb_checker u_mesisb_checker (.*);

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the MESI snooping bus controller: every accepted request is run
// through a cycle-free model of the bus, the caches and main memory, and each
// response is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mesisb_pkg::*;

   localparam int WATCHDOG_LIMIT = 8_000_000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [2:0]          req_cmd;
   logic [1:0]          req_core;
   logic [ADDR_W-1:0]   req_address;
   logic                req_exclusive;
   logic [31:0]         req_data_in;
   logic [TAG_W-1:0]    req_tag_in;
   logic [1:0]          req_state_in;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_bus_cmd_out;
   logic [1:0]          rsp_bus_origin;
   logic [ADDR_W-1:0]   rsp_bus_addr_out;
   logic [31:0]         rsp_bus_data_out;
   logic                rsp_bus_shared_out;
   logic [3:0]          rsp_done_mask;
   logic [3:0]          rsp_pending_mask;
   logic [31:0]         rsp_read_word;
   logic [31:0]         rsp_cache_word;
   logic [TAG_W-1:0]    rsp_line_tag;
   logic [1:0]          rsp_line_state;
   logic [ADDR_W-1:0]   rsp_max_addr;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   mesi_snoop_bus_controller_core u_dut (.*);

   // bus model state
   logic [DELAY_W-1:0]  m_delay;
   logic [3:0]          m_pending, m_done, m_excl;
   logic [ADDR_W-1:0]   m_req_addr [4];
   logic                m_busy, m_shared, m_pf_valid;
   logic [7:0]          m_cooldown;
   logic [3:0]          m_word;
   logic [1:0]          m_cmd, m_origin, m_pf_state, m_last;
   logic [ADDR_W-1:0]   m_addr, m_highest;
   logic [31:0]         m_data;
   logic [TAG_W-1:0]    m_tag [4][LINES];
   logic [1:0]          m_state [4][LINES];
   logic [31:0]         m_line_data [4][LINES][BLOCK_WORDS];
   logic [31:0]         m_memory [int unsigned];

   rsp_type             rsp_expected_q [$];
   int                  fail_count;
   int                  idle_cycles;
   bit                  no_idling;
   int                  stall_left;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] mem_read(logic [ADDR_W-1:0] p);
      return m_memory.exists(p) ? m_memory[p] : 32'd0;
   endfunction

   function automatic void model_reset();
      m_delay = BUS_DELAY_RESET;
      m_pending = '0; m_done = '0; m_excl = '0;
      m_busy = 0; m_shared = 0; m_pf_valid = 0;
      m_cooldown = 0; m_word = 0;
      m_cmd = BC_NONE; m_origin = 0; m_addr = 0; m_data = 0;
      m_pf_state = MESI_I; m_last = 0; m_highest = 0;
      m_memory.delete();
      for (int c = 0; c < 4; c++) begin
         m_req_addr[c] = 0;
         for (int l = 0; l < LINES; l++) begin
            m_tag[c][l] = 0;
            m_state[c][l] = MESI_I;
            for (int w = 0; w < BLOCK_WORDS; w++) m_line_data[c][l][w] = 0;
         end
      end
   endfunction

   function automatic void start_transfer(logic [1:0] cmd, logic [1:0] origin,
                                          logic [ADDR_W-1:0] addr, logic [7:0] delay);
      m_busy = 1; m_cmd = cmd; m_origin = origin; m_addr = addr;
      m_cooldown = delay; m_word = 0;
   endfunction

   function automatic void grant_next();
      logic [1:0]        id;
      logic [ADDR_W-1:0] addr;
      logic [5:0]        idx;
      logic [TAG_W-1:0]  tag;
      logic              rd;
      for (int i = 0; i < 4; i++) begin
         id = m_last + 2'd1 + 2'(i);
         if (!m_pending[id] || m_done[id]) continue;
         addr = m_req_addr[id];
         idx = addr[8:3];
         tag = addr[20:9];
         rd = !m_excl[id];
         m_shared = 0;
         // the requester's own dirty line in the way goes out first
         if (m_state[id][idx] == MESI_M && m_tag[id][idx] != tag) begin
            m_pf_state = MESI_I;
            m_pf_valid = 1;
            start_transfer(BC_FLUSH, id, {m_tag[id][idx], idx, 3'b000}, 0);
            return;
         end
         for (int c = 0; c < 4; c++) begin
            if (c == id) continue;
            if (m_state[c][idx] == MESI_I || m_tag[c][idx] != tag) continue;
            m_shared = 1;
            if (rd && m_state[c][idx] == MESI_E) m_state[c][idx] = MESI_S;
            if (m_state[c][idx] == MESI_M) begin
               m_pf_state = rd ? MESI_S : MESI_I;
               m_pf_valid = 1;
               start_transfer(BC_FLUSH, 2'(c), addr, 0);
               return;
            end
            if (!rd) m_state[c][idx] = MESI_I;
         end
         start_transfer(rd ? BC_RD : BC_RDX, id, addr, m_delay);
         return;
      end
   endfunction

   function automatic void bus_tick();
      logic [5:0]        idx;
      logic [2:0]        w;
      logic [ADDR_W-1:0] p;
      if (!m_busy) begin
         m_cmd = BC_NONE; m_origin = 0; m_addr = 0; m_data = 0;
         m_shared = 0; m_pf_valid = 0;
         grant_next();
         return;
      end
      if (m_cooldown > 0) begin
         m_cooldown--;
         return;
      end
      idx = m_addr[8:3];
      w = m_word[2:0];
      p = {m_addr[20:3], w};
      if (m_cmd == BC_RD || m_cmd == BC_RDX) begin
         m_data = mem_read(p);
         if (p > m_highest) m_highest = p;
         m_line_data[m_origin][idx][w] = m_data;
      end else if (m_cmd == BC_FLUSH) begin
         m_data = m_line_data[m_origin][idx][w];
         m_memory[p] = m_data;
         if (p > m_highest) m_highest = p;
      end
      m_word++;
      if (m_word < BLOCK_WORDS) return;
      if (m_cmd == BC_RD) begin
         m_state[m_origin][idx] = m_shared ? MESI_S : MESI_E;
         m_tag[m_origin][idx] = m_addr[20:9];
      end else if (m_cmd == BC_RDX) begin
         m_state[m_origin][idx] = MESI_M;
         m_tag[m_origin][idx] = m_addr[20:9];
      end else if (m_cmd == BC_FLUSH) begin
         m_state[m_origin][idx] = m_pf_valid ? m_pf_state : MESI_I;
         m_pf_valid = 0;
      end
      if (m_cmd != BC_FLUSH) begin
         m_done[m_origin] = 1;
         m_pending[m_origin] = 0;
      end
      m_busy = 0;
      m_last = m_origin;
      m_word = 0;
   endfunction

   function automatic rsp_type predict_bus(logic [2:0] cmd, logic [1:0] core,
                                           logic [ADDR_W-1:0] addr, logic excl,
                                           logic [31:0] din, logic [TAG_W-1:0] tin,
                                           logic [1:0] sin);
      rsp_type r;
      r = '0;
      case (cmd)
         CMD_TICK: bus_tick();
         CMD_REQUEST: begin
            if (!m_pending[core]) begin
               m_req_addr[core] = addr;
               m_excl[core] = excl;
               m_pending[core] = 1;
               m_done[core] = 0;
            end
         end
         CMD_CWRITE: m_line_data[core][addr[8:3]][addr[2:0]] = din;
         CMD_LWRITE: begin
            m_tag[core][addr[8:3]] = tin;
            m_state[core][addr[8:3]] = sin;
         end
         CMD_MWRITE: m_memory[addr] = din;
         CMD_INSPECT: begin
            r.read_word = mem_read(addr);
            r.cache_word = m_line_data[core][addr[8:3]][addr[2:0]];
            r.line_tag = m_tag[core][addr[8:3]];
            r.line_state = m_state[core][addr[8:3]];
         end
         default: ;
      endcase
      r.bus_cmd = m_cmd;
      r.origin = m_origin;
      r.addr = m_addr;
      r.data = m_data;
      r.shared = m_shared;
      r.done = m_done;
      r.pending = m_pending;
      r.max_addr = m_highest;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idling) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_request(logic [2:0] cmd, logic [1:0] core, logic [ADDR_W-1:0] addr,
                               logic excl, logic [31:0] din, logic [TAG_W-1:0] tin,
                               logic [1:0] sin);
      int gap;
      req_valid <= 1;
      req_cmd <= cmd;
      req_core <= core;
      req_address <= addr;
      req_exclusive <= excl;
      req_data_in <= din;
      req_tag_in <= tin;
      req_state_in <= sin;
      do @(posedge clock); while (!(req_valid && !req_stall));
      rsp_expected_q.push_back(predict_bus(cmd, core, addr, excl, din, tin, sin));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_valid <= 0;
      while (rsp_expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_bus_delay(logic [7:0] value);
      drain_and_settle();
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= '0; csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      m_delay = value;
      @(posedge clock);
   endtask

   // addresses cluster on a few tags and lines so that cores collide
   function automatic logic [ADDR_W-1:0] pick_addr();
      logic [TAG_W-1:0] tag;
      logic [5:0]       line;
      case ($urandom_range(0, 4))
         0: tag = 0;
         1: tag = 1;
         2: tag = 12'hFFF;
         3: tag = 12'(2 + $urandom_range(0, 1));
         default: tag = 12'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: line = 0;
         1: line = 6'h3F;
         2: line = 6'($urandom_range(1, 2));
         default: line = 6'($urandom);
      endcase
      return {tag, line, 3'($urandom)};
   endfunction

   task automatic send_random(int tick_weight);
      int          r;
      logic [2:0]  cmd;
      r = $urandom_range(0, 99);
      if (r < tick_weight) cmd = CMD_TICK;
      else if (r < tick_weight + 14) cmd = CMD_REQUEST;
      else if (r < tick_weight + 19) cmd = CMD_CWRITE;
      else if (r < tick_weight + 25) cmd = CMD_LWRITE;
      else if (r < tick_weight + 30) cmd = CMD_MWRITE;
      else if (r < 98) cmd = CMD_INSPECT;
      else cmd = 3'($urandom_range(6, 7));
      send_request(cmd, 2'($urandom), pick_addr(), 1'($urandom), $urandom,
                   12'($urandom), 2'($urandom));
   endtask

   task automatic test_directed();
      write_bus_delay(8'd1);
      send_request(CMD_MWRITE, 0, 21'h1FFFFF, 0, 32'hFFFFFFFF, 0, 0);
      send_request(CMD_MWRITE, 0, 21'h000009, 0, 32'hA5A5_0001, 0, 0);
      send_request(CMD_INSPECT, 3, 21'h1FFFFF, 1, 32'hFFFFFFFF, 12'hFFF, 2'd3);
      send_request(3'd6, 3, 21'h1FFFFF, 1, 32'hFFFFFFFF, 12'hFFF, MESI_M);
      send_request(3'd7, 0, 0, 0, 0, 0, MESI_I);
      // dirty line under another tag: evicted before the read
      send_request(CMD_LWRITE, 3, 21'h0001F8, 0, 0, 12'hFFF, MESI_M);
      send_request(CMD_CWRITE, 3, 21'h0001FF, 0, 32'hDEAD_BEEF, 0, 0);
      send_request(CMD_REQUEST, 3, 21'h0001F8, 0, 0, 0, 0);
      send_request(CMD_REQUEST, 0, 21'h000008, 1, 0, 0, 0);
      send_request(CMD_REQUEST, 0, 21'h1FFFF8, 0, 0, 0, 0); // ignored, already pending
      send_request(CMD_LWRITE, 1, 21'h000008, 0, 0, 12'h000, MESI_E);
      send_request(CMD_REQUEST, 2, 21'h000008, 0, 0, 0, 0);
      repeat (60) send_request(CMD_TICK, 0, 0, 0, 0, 0, 0);
      send_request(CMD_INSPECT, 3, 21'h1FFFFF, 0, 0, 0, 0);
      send_request(CMD_INSPECT, 0, 21'h00000F, 0, 0, 0, 0);
      send_request(CMD_INSPECT, 1, 21'h000008, 0, 0, 0, 0);
   endtask

   task automatic test_no_delay();
      write_bus_delay(8'd0);
      no_idling = 1;
      repeat (30) send_random(55);
      no_idling = 0;
      repeat (70) send_random(55);
   endtask

   task automatic test_max_delay();
      write_bus_delay(8'd255);
      send_request(CMD_REQUEST, 1, pick_addr(), 1, 0, 0, 0);
      repeat (300) send_random(85);
   endtask

   task automatic test_random_delay();
      repeat (3) begin
         write_bus_delay(8'($urandom_range(1, 6)));
         repeat (35) send_random(55);
      end
   endtask

   // response side: random stall with runs of none
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (no_idling || r < 75) rsp_stall <= 0;
         else if (r < 96) begin
            rsp_stall <= 1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1;
            stall_left <= $urandom_range(8, 30);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expected_q.size() == 0) begin
            $error("response with no request waiting");
            fail_count++;
         end else begin
            e = rsp_expected_q.pop_front();
            if (rsp_bus_cmd_out !== e.bus_cmd) begin
               $error("bus_cmd_out: expected %0d, got %0d", e.bus_cmd, rsp_bus_cmd_out);
               fail_count++;
            end
            if (rsp_bus_origin !== e.origin) begin
               $error("bus_origin: expected %0d, got %0d", e.origin, rsp_bus_origin);
               fail_count++;
            end
            if (rsp_bus_addr_out !== e.addr) begin
               $error("bus_addr_out: expected %h, got %h", e.addr, rsp_bus_addr_out);
               fail_count++;
            end
            if (rsp_bus_data_out !== e.data) begin
               $error("bus_data_out: expected %h, got %h", e.data, rsp_bus_data_out);
               fail_count++;
            end
            if (rsp_bus_shared_out !== e.shared) begin
               $error("bus_shared_out: expected %0d, got %0d", e.shared, rsp_bus_shared_out);
               fail_count++;
            end
            if (rsp_done_mask !== e.done) begin
               $error("done_mask: expected %b, got %b", e.done, rsp_done_mask);
               fail_count++;
            end
            if (rsp_pending_mask !== e.pending) begin
               $error("pending_mask: expected %b, got %b", e.pending, rsp_pending_mask);
               fail_count++;
            end
            if (rsp_read_word !== e.read_word) begin
               $error("read_word: expected %h, got %h", e.read_word, rsp_read_word);
               fail_count++;
            end
            if (rsp_cache_word !== e.cache_word) begin
               $error("cache_word: expected %h, got %h", e.cache_word, rsp_cache_word);
               fail_count++;
            end
            if (rsp_line_tag !== e.line_tag) begin
               $error("line_tag: expected %h, got %h", e.line_tag, rsp_line_tag);
               fail_count++;
            end
            if (rsp_line_state !== e.line_state) begin
               $error("line_state: expected %0d, got %0d", e.line_state, rsp_line_state);
               fail_count++;
            end
            if (rsp_max_addr !== e.max_addr) begin
               $error("max_addr: expected %h, got %h", e.max_addr, rsp_max_addr);
               fail_count++;
            end
         end
      end
   end

   // idle watchdog; its limit covers the memory clearing pass after reset
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      fail_count = 0;
      idle_cycles = 0;
      no_idling = 0;
      reset = 1;
      req_valid = 0;
      req_cmd = CMD_TICK; req_core = 0; req_address = 0; req_exclusive = 0;
      req_data_in = 0; req_tag_in = 0; req_state_in = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      model_reset();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_no_delay();
      test_max_delay();
      test_random_delay();
      drain_and_settle();
      if (fail_count == 0 && rsp_expected_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
